// ===== sv/spbb_pkg.sv =====
// Shared types, constants and arithmetic helpers for the skewed polygon bounding box block.
package spbb_pkg;

    // Field widths.
    localparam int COORD_W = 16;
    localparam int SKEW_W  = 13;
    localparam int ROT_W   = 18;

    // The shear tangent is in units of 1/2048, so a product is scaled back by 11 bits.
    localparam int SKEW_SHIFT = 11;

    // Product widths for the two shear multiplies.
    localparam int PROD1_W = COORD_W + SKEW_W;
    localparam int PROD2_W = ROT_W + SKEW_W;
    localparam int QUOT_W  = PROD2_W - SKEW_SHIFT;

    // Limits of the usable shear tangent.
    localparam logic signed [SKEW_W-1:0] SKEW_HI = SKEW_W'(1 << SKEW_SHIFT);
    localparam logic signed [SKEW_W-1:0] SKEW_LO = -SKEW_W'(1 << SKEW_SHIFT);

    // Bias that turns an arithmetic shift into a division truncating toward zero.
    localparam logic signed [PROD2_W-1:0] SHEAR_BIAS = PROD2_W'((1 << SKEW_SHIFT) - 1);

    // Rotation pipeline depth and the decoupling queue between front and back.
    localparam int FRONT_STAGES = 3;
    localparam int QDEPTH       = 8;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QLVL_W       = $clog2(QDEPTH + 1);
    localparam int CREDIT_W     = $clog2(QDEPTH + FRONT_STAGES + 1);

    // One rotated corner as it waits in the queue.
    typedef struct packed {
        logic signed [ROT_W-1:0] xr;
        logic signed [ROT_W-1:0] yr;
        logic                    last;
    } corner_t;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic [QLVL_W-1:0] level;
        logic              head_valid;
    } queue_stat_t;

    // Clamp a written shear tangent to the range of a unit shear.
    function automatic logic signed [SKEW_W-1:0] clamp_skew(input logic signed [SKEW_W-1:0] s);
        logic signed [SKEW_W-1:0] r;
        if (s < SKEW_LO)
        begin
            r = SKEW_LO;
        end
        else if (s > SKEW_HI)
        begin
            r = SKEW_HI;
        end
        else
        begin
            r = s;
        end
        return r;
    endfunction

    // Divide a product by 2048, truncating toward zero.
    function automatic logic signed [QUOT_W-1:0] shear_scale(input logic signed [PROD2_W-1:0] p);
        logic signed [PROD2_W-1:0] adj;
        adj = p[PROD2_W-1] ? (p + SHEAR_BIAS) : p;
        return adj[PROD2_W-1:SKEW_SHIFT];
    endfunction

endpackage

// ===== sv/spbb_front.sv =====
// Front end: holds the shear register and rotates each accepted corner in a three stage pipeline.
module spbb_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  skew_wr_en,
    input  logic signed [spbb_pkg::SKEW_W-1:0]    skew_wr_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [spbb_pkg::COORD_W-1:0]   corner_x,
    input  logic signed [spbb_pkg::COORD_W-1:0]   corner_y,
    input  logic                                  last_corner,
    input  spbb_pkg::queue_stat_t                 qstat,
    output logic                                  push,
    output spbb_pkg::corner_t                     push_data
);

    logic signed [spbb_pkg::SKEW_W-1:0]  skew_reg;
    logic signed [spbb_pkg::SKEW_W-1:0]  skew_next;

    logic [spbb_pkg::FRONT_STAGES-1:0]   valid_reg;
    logic [spbb_pkg::FRONT_STAGES-1:0]   valid_next;

    // Stage 1: first product x * skew.
    logic signed [spbb_pkg::PROD1_W-1:0] p1_reg;
    logic signed [spbb_pkg::COORD_W-1:0] x1_reg;
    logic signed [spbb_pkg::COORD_W-1:0] y1_reg;
    logic                                last1_reg;

    // Stage 2: sheared y.
    logic signed [spbb_pkg::ROT_W-1:0]   yr2_reg;
    logic signed [spbb_pkg::COORD_W-1:0] x2_reg;
    logic                                last2_reg;

    // Stage 3: second product yr * skew.
    logic signed [spbb_pkg::PROD2_W-1:0] p2_reg;
    logic signed [spbb_pkg::ROT_W-1:0]   yr3_reg;
    logic signed [spbb_pkg::COORD_W-1:0] x3_reg;
    logic                                last3_reg;

    logic signed [spbb_pkg::QUOT_W-1:0]  q1;
    logic signed [spbb_pkg::QUOT_W-1:0]  q2;
    logic signed [spbb_pkg::ROT_W-1:0]   yr2;
    logic [spbb_pkg::CREDIT_W-1:0]       credit_used;
    logic                                accept;

    // Every corner in flight already owns a queue slot, so the pipeline never stalls.
    assign credit_used = spbb_pkg::CREDIT_W'(qstat.level)
                       + spbb_pkg::CREDIT_W'($countones(valid_reg));
    assign in_stall    = (credit_used >= spbb_pkg::CREDIT_W'(spbb_pkg::QDEPTH));
    assign accept      = in_valid && !in_stall;

    assign skew_next  = skew_wr_en ? spbb_pkg::clamp_skew(skew_wr_data) : skew_reg;
    assign valid_next = {valid_reg[spbb_pkg::FRONT_STAGES-2:0], accept};

    assign q1  = spbb_pkg::shear_scale(spbb_pkg::PROD2_W'(p1_reg));
    assign yr2 = spbb_pkg::ROT_W'(y1_reg) - q1[spbb_pkg::ROT_W-1:0];
    assign q2  = spbb_pkg::shear_scale(p2_reg);

    assign push           = valid_reg[spbb_pkg::FRONT_STAGES-1];
    assign push_data.xr   = spbb_pkg::ROT_W'(x3_reg) + q2[spbb_pkg::ROT_W-1:0];
    assign push_data.yr   = yr3_reg;
    assign push_data.last = last3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skew_reg  <= '0;
            valid_reg <= '0;
        end
        else
        begin
            skew_reg  <= skew_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg    <= spbb_pkg::PROD1_W'(corner_x) * spbb_pkg::PROD1_W'(skew_reg);
        x1_reg    <= corner_x;
        y1_reg    <= corner_y;
        last1_reg <= last_corner;

        yr2_reg   <= yr2;
        x2_reg    <= x1_reg;
        last2_reg <= last1_reg;

        p2_reg    <= spbb_pkg::PROD2_W'(yr2_reg) * spbb_pkg::PROD2_W'(skew_reg);
        yr3_reg   <= yr2_reg;
        x3_reg    <= x2_reg;
        last3_reg <= last2_reg;
    end

`ifndef SYNTHESIS
    // Corners in the pipeline plus corners queued never outnumber the queue slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        credit_used <= spbb_pkg::CREDIT_W'(spbb_pkg::QDEPTH))
        else $error("front: more corners in flight than queue slots");
`endif

endmodule

// ===== sv/spbb_queue.sv =====
// Short queue of rotated corners between the front end and the accumulator.
module spbb_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  spbb_pkg::corner_t      push_data,
    input  logic                   pop,
    output spbb_pkg::corner_t      head,
    output spbb_pkg::queue_stat_t  qstat
);

    spbb_pkg::corner_t                entry_reg [spbb_pkg::QDEPTH];
    logic [spbb_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [spbb_pkg::QPTR_W-1:0]      wr_ptr_next;
    logic [spbb_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [spbb_pkg::QPTR_W-1:0]      rd_ptr_next;
    logic [spbb_pkg::QLVL_W-1:0]      level_reg;
    logic [spbb_pkg::QLVL_W-1:0]      level_next;

    assign head             = entry_reg[rd_ptr_reg];
    assign qstat.level      = level_reg;
    assign qstat.head_valid = (level_reg != '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTHESIS
    // A write never lands in a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (level_reg != spbb_pkg::QLVL_W'(spbb_pkg::QDEPTH)))
        else $error("queue: push while full");

    // A read never takes from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (level_reg != '0))
        else $error("queue: pop while empty");
`endif

endmodule

// ===== sv/spbb_back.sv =====
// Back end: running minimum and maximum of rotated corners and the registered box result.
module spbb_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  spbb_pkg::corner_t                   head,
    input  spbb_pkg::queue_stat_t               qstat,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [spbb_pkg::ROT_W-1:0]   left_x,
    output logic signed [spbb_pkg::ROT_W-1:0]   top_y,
    output logic [spbb_pkg::ROT_W-1:0]          box_width,
    output logic [spbb_pkg::ROT_W-1:0]          box_height
);

    logic signed [spbb_pkg::ROT_W-1:0] min_x_reg, min_x_next;
    logic signed [spbb_pkg::ROT_W-1:0] min_y_reg, min_y_next;
    logic signed [spbb_pkg::ROT_W-1:0] max_x_reg, max_x_next;
    logic signed [spbb_pkg::ROT_W-1:0] max_y_reg, max_y_next;
    logic                              first_reg, first_next;
    logic                              out_valid_reg, out_valid_next;
    logic signed [spbb_pkg::ROT_W-1:0] left_reg, left_next;
    logic signed [spbb_pkg::ROT_W-1:0] top_reg, top_next;
    logic [spbb_pkg::ROT_W-1:0]        width_reg, width_next;
    logic [spbb_pkg::ROT_W-1:0]        height_reg, height_next;

    logic signed [spbb_pkg::ROT_W-1:0] hx;
    logic signed [spbb_pkg::ROT_W-1:0] hy;
    logic signed [spbb_pkg::ROT_W-1:0] nmin_x, nmin_y, nmax_x, nmax_y;
    logic                              pop_last;

    assign hx = head.xr;
    assign hy = head.yr;

    // A last corner waits only while the previous box still sits unread in the output.
    assign pop      = qstat.head_valid && !(head.last && out_valid_reg && out_stall);
    assign pop_last = pop && head.last;

    always_comb
    begin
        if (first_reg)
        begin
            nmin_x = hx;
            nmax_x = hx;
            nmin_y = hy;
            nmax_y = hy;
        end
        else
        begin
            nmin_x = (hx < min_x_reg) ? hx : min_x_reg;
            nmax_x = (hx > max_x_reg) ? hx : max_x_reg;
            nmin_y = (hy < min_y_reg) ? hy : min_y_reg;
            nmax_y = (hy > max_y_reg) ? hy : max_y_reg;
        end
    end

    always_comb
    begin
        min_x_next     = min_x_reg;
        min_y_next     = min_y_reg;
        max_x_next     = max_x_reg;
        max_y_next     = max_y_reg;
        first_next     = first_reg;
        left_next      = left_reg;
        top_next       = top_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (pop)
        begin
            min_x_next = nmin_x;
            min_y_next = nmin_y;
            max_x_next = nmax_x;
            max_y_next = nmax_y;
            first_next = head.last;
        end
        if (pop_last)
        begin
            left_next      = nmin_x;
            top_next       = nmin_y;
            width_next     = nmax_x - nmin_x;
            height_next    = nmax_y - nmin_y;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg     <= '0;
            min_y_reg     <= '0;
            max_x_reg     <= '0;
            max_y_reg     <= '0;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            min_x_reg     <= min_x_next;
            min_y_reg     <= min_y_next;
            max_x_reg     <= max_x_next;
            max_y_reg     <= max_y_next;
            first_reg     <= first_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg   <= left_next;
        top_reg    <= top_next;
        width_reg  <= width_next;
        height_reg <= height_next;
    end

    assign out_valid  = out_valid_reg;
    assign left_x     = left_reg;
    assign top_y      = top_reg;
    assign box_width  = width_reg;
    assign box_height = height_reg;

`ifndef SYNTHESIS
    // Taking a last corner always presents a box in the next cycle and rearms the accumulator.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop_last |=> (out_valid_reg && first_reg))
        else $error("back: last corner did not produce a box");
`endif

endmodule

// ===== sv/skewed_polygon_bounding_box.sv =====
// Top level of the skewed polygon bounding box block.
//
// Corners of a polygon arrive one per input transaction on corner_x, corner_y and
// last_corner, under in_valid and in_stall. Each corner is deskewed by two shear steps
// using the skew register, and the block tracks the minimum and maximum of the rotated
// coordinates. The corner marked last produces one output transaction carrying left_x,
// top_y, box_width and box_height under out_valid and out_stall; other corners give none.
// The skew register is written through skew_wr_en and skew_wr_data. The user must write it
// only while idle; the block itself does not enforce this. Values beyond a unit shear are
// clamped when written. Throughput is one corner per cycle while in_stall is low. A corner
// passes the rotation pipeline, then the queue, and the box is registered when the last
// corner leaves the queue. in_stall rises when the corners in the pipeline and the queue
// together fill the eight queue slots, which is what limits the intake under output stall.
// While out_stall holds a box, non-last corners keep accumulating; a following last corner
// waits in the queue until the box is taken. Reset clears skew to zero, empties the
// pipeline and queue, and makes the next corner start a new polygon.
module skewed_polygon_bounding_box (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                skew_wr_en,
    input  logic signed [spbb_pkg::SKEW_W-1:0]  skew_wr_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [spbb_pkg::COORD_W-1:0] corner_x,
    input  logic signed [spbb_pkg::COORD_W-1:0] corner_y,
    input  logic                                last_corner,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [spbb_pkg::ROT_W-1:0]   left_x,
    output logic signed [spbb_pkg::ROT_W-1:0]   top_y,
    output logic [spbb_pkg::ROT_W-1:0]          box_width,
    output logic [spbb_pkg::ROT_W-1:0]          box_height
);

    logic                  push;
    logic                  pop;
    spbb_pkg::corner_t     push_data;
    spbb_pkg::corner_t     head;
    spbb_pkg::queue_stat_t qstat;

    // Rotation front end; it reserves a queue slot for every corner it takes.
    spbb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .skew_wr_en   (skew_wr_en),
        .skew_wr_data (skew_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .corner_x     (corner_x),
        .corner_y     (corner_y),
        .last_corner  (last_corner),
        .qstat        (qstat),
        .push         (push),
        .push_data    (push_data)
    );

    // Decoupling queue so the rotation keeps running while the output is stalled.
    spbb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    // Accumulator and output register.
    spbb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .qstat      (qstat),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .left_x     (left_x),
        .top_y      (top_y),
        .box_width  (box_width),
        .box_height (box_height)
    );

endmodule
